// ===== hw/rtl/aidsr_pkg.sv =====
package aidsr_pkg;

	localparam int OP_W   = 3;
	localparam int LEN_W  = 5;
	localparam int SVC_W  = 8;
	localparam int SW_W   = 16;
	localparam int BYTE_W = 8;
	localparam int RAW_W  = 128;

	localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
	localparam logic [OP_W-1:0] OP_SHUTDOWN  = 3'd1;
	localparam logic [OP_W-1:0] OP_REGISTER  = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
	localparam logic [OP_W-1:0] OP_FIELD_OFF = 3'd4;
	localparam logic [OP_W-1:0] OP_APDU      = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_ALREADY     = 3'd1;
	localparam logic [2:0] ST_NOT_INIT    = 3'd2;
	localparam logic [2:0] ST_INVALID_ARG = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_SEND   = 3'd1;
	localparam logic [2:0] ACT_SELECT = 3'd2;
	localparam logic [2:0] ACT_ROUTE  = 3'd3;
	localparam logic [2:0] ACT_NOTIFY = 3'd4;

	localparam logic [7:0] CLA_ISO    = 8'h00;
	localparam logic [7:0] INS_SELECT = 8'hA4;
	localparam logic [7:0] P1_BY_AID  = 8'h04;

	localparam logic [SW_W-1:0] SW_NOT_FOUND_RST    = 16'h6A82;
	localparam logic [SW_W-1:0] SW_NO_SELECTION_RST = 16'h6986;

	localparam logic CFG_SW_NOT_FOUND    = 1'b0;
	localparam logic CFG_SW_NO_SELECTION = 1'b1;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       action;
		logic [SW_W-1:0]  status_word;
		logic [SVC_W-1:0] service;
		logic             deselect_valid;
		logic [SVC_W-1:0] deselect_service;
	} res_t;

	// keep the first n bytes of {hi, lo}, zero the rest
	function automatic logic [RAW_W-1:0] keep_bytes(input logic [63:0] hi,
		input logic [63:0] lo, input logic [7:0] n);
		logic [RAW_W-1:0] raw;
		logic [RAW_W-1:0] res;
		raw = {hi, lo};
		res = '0;
		for (int b = 0; b < RAW_W / BYTE_W; b++) begin
			if (8'(b) < n) begin
				res[RAW_W-1-b*BYTE_W -: BYTE_W] = raw[RAW_W-1-b*BYTE_W -: BYTE_W];
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/aidsr_in_if.sv =====
interface aidsr_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [63:0] aid_hi;
	logic [63:0] aid_lo;
	logic [7:0]  aid_len;
	logic [7:0]  service_id;
	logic [7:0]  cla;
	logic [7:0]  ins;
	logic [7:0]  p1;
	logic [7:0]  lc;

	modport source (output valid, operation, aid_hi, aid_lo, aid_len, service_id,
		cla, ins, p1, lc, input ready);
	modport sink (input valid, operation, aid_hi, aid_lo, aid_len, service_id,
		cla, ins, p1, lc, output ready);
endinterface

// ===== hw/rtl/aidsr_out_if.sv =====
interface aidsr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  action;
	logic [15:0] status_word;
	logic [7:0]  service;
	logic        deselect_valid;
	logic [7:0]  deselect_service;

	modport source (output valid, status, action, status_word, service,
		deselect_valid, deselect_service, input ready);
	modport sink (input valid, status, action, status_word, service,
		deselect_valid, deselect_service, output ready);
endinterface

// ===== hw/rtl/aid_select_router_unit.sv =====
// Sequence: an input transfer moves from idle to decode and on to done, where
//   the result enters the output register; a SELECT-by-AID walk instead steps
//   from decode through the table entries, one read per entry, before done.
// Flow: one item at a time, a new input transfer only once the result has
//   entered the output register; a held-off output stalls that. The entry walk
//   goes through the single shared comparator and the table RAM read port.
// Reset (arst_n low): router uninitialized, table empty, no active service,
//   status words back to their defaults, output register empty.
module aid_select_router_unit import aidsr_pkg::*; #(
	parameter int MAX_ENTRIES = 8,
	parameter int AID_BYTES   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	aidsr_in_if.sink          req,
	aidsr_out_if.source       rsp,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [SW_W-1:0]   cfg_data
);
	localparam int KEY_W = AID_BYTES * BYTE_W;
	localparam int ENT_W = SVC_W + LEN_W + KEY_W;
	localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEC  = 2'd1;
	localparam logic [1:0] S_SRCH = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;

	// configuration
	logic [SW_W-1:0]  sw_not_found_q;
	logic [SW_W-1:0]  sw_no_sel_q;

	// router state
	logic             ready_flag_q;
	logic [CW-1:0]    count_q;
	logic             active_valid_q;
	logic [SVC_W-1:0] active_svc_q;

	// latched item
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [7:0]       aid_len_q;
	logic [SVC_W-1:0] svc_in_q;
	logic             is_select_q;
	logic [7:0]       lc_q;

	// entry walk
	logic [CW-1:0]    ic_q;
	logic             rv_q;

	res_t             res_q;

	// output register
	logic             out_valid_q;
	res_t             out_q;

	logic [RAW_W-1:0] masked;
	logic             ram_we;
	logic             ram_re;
	logic [ENT_W-1:0] ram_wdata;
	logic [ENT_W-1:0] ram_rdata;
	logic             hit;
	logic [SVC_W-1:0] hit_svc;

	// key masked at transfer time: by aid_len for register, by lc otherwise
	assign masked = keep_bytes(req.aid_hi, req.aid_lo,
		(req.operation == OP_REGISTER) ? req.aid_len : req.lc);

	assign req.ready = (state_q == S_IDLE);

	// a register writes the next free slot during decode
	assign ram_we = (state_q == S_DEC) && (op_q == OP_REGISTER) && ready_flag_q &&
		(aid_len_q != 8'd0) && (aid_len_q <= 8'(AID_BYTES)) &&
		(count_q != CW'(MAX_ENTRIES));
	assign ram_wdata = {svc_in_q, aid_len_q[LEN_W-1:0], key_q};
	assign ram_re = (state_q == S_SRCH) && (ic_q != count_q);

	aidsr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ic_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	aidsr_cmp #(
		.KEY_W (KEY_W)
	) u_cmp (
		.entry   (ram_rdata),
		.key     (key_q),
		.key_len (lc_q[LEN_W-1:0]),
		.hit     (hit),
		.svc     (hit_svc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_not_found_q <= SW_NOT_FOUND_RST;
			sw_no_sel_q    <= SW_NO_SELECTION_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_SW_NOT_FOUND) begin
				sw_not_found_q <= cfg_data;
			end else begin
				sw_no_sel_q <= cfg_data;
			end
		end
	end

	// latched item fields, payload only
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q        <= req.operation;
			key_q       <= masked[RAW_W-1 -: KEY_W];
			aid_len_q   <= req.aid_len;
			svc_in_q    <= req.service_id;
			lc_q        <= req.lc;
			is_select_q <= (req.cla == CLA_ISO) && (req.ins == INS_SELECT) &&
				(req.p1 == P1_BY_AID) && (req.lc != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ready_flag_q   <= 1'b0;
			count_q        <= '0;
			active_valid_q <= 1'b0;
			active_svc_q   <= '0;
			ic_q           <= '0;
			rv_q           <= 1'b0;
			res_q          <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_q   <= '0;
					state_q <= S_DONE;
					case (op_q)
						OP_INIT: begin
							if (ready_flag_q) begin
								res_q.status <= ST_ALREADY;
							end else begin
								count_q        <= '0;
								active_valid_q <= 1'b0;
								active_svc_q   <= '0;
								ready_flag_q   <= 1'b1;
							end
						end
						OP_SHUTDOWN: begin
							count_q        <= '0;
							active_valid_q <= 1'b0;
							active_svc_q   <= '0;
							ready_flag_q   <= 1'b0;
						end
						OP_REGISTER: begin
							if (!ready_flag_q) begin
								res_q.status <= ST_NOT_INIT;
							end else if (aid_len_q == 8'd0 ||
								aid_len_q > 8'(AID_BYTES)) begin
								res_q.status <= ST_INVALID_ARG;
							end else if (count_q == CW'(MAX_ENTRIES)) begin
								res_q.status <= ST_TABLE_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_CLEAR: begin
							count_q        <= '0;
							active_valid_q <= 1'b0;
							active_svc_q   <= '0;
						end
						OP_FIELD_OFF: begin
							if (active_valid_q) begin
								res_q.action  <= ACT_NOTIFY;
								res_q.service <= active_svc_q;
							end
							active_valid_q <= 1'b0;
							active_svc_q   <= '0;
						end
						OP_APDU: begin
							if (!ready_flag_q) begin
								res_q.status <= ST_NOT_INIT;
							end else if (is_select_q) begin
								if (lc_q > 8'(AID_BYTES)) begin
									// longer than any entry: cannot match
									res_q.action      <= ACT_SEND;
									res_q.status_word <= sw_not_found_q;
								end else begin
									ic_q    <= '0;
									rv_q    <= 1'b0;
									state_q <= S_SRCH;
								end
							end else if (!active_valid_q) begin
								res_q.action      <= ACT_SEND;
								res_q.status_word <= sw_no_sel_q;
							end else begin
								res_q.action  <= ACT_ROUTE;
								res_q.service <= active_svc_q;
							end
						end
						default: begin
							res_q.status <= ST_INVALID_ARG;
						end
					endcase
				end
				S_SRCH: begin
					// read of entry ic_q overlaps compare of the previous one
					rv_q <= ram_re;
					if (ram_re) begin
						ic_q <= ic_q + CW'(1);
					end
					if (rv_q && hit) begin
						res_q.action  <= ACT_SELECT;
						res_q.service <= hit_svc;
						if (active_valid_q && active_svc_q != hit_svc) begin
							res_q.deselect_valid   <= 1'b1;
							res_q.deselect_service <= active_svc_q;
						end
						active_valid_q <= 1'b1;
						active_svc_q   <= hit_svc;
						state_q        <= S_DONE;
					end else if (ic_q == count_q) begin
						res_q.action      <= ACT_SEND;
						res_q.status_word <= sw_not_found_q;
						state_q           <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_q.status;
	assign rsp.action           = out_q.action;
	assign rsp.status_word      = out_q.status_word;
	assign rsp.service          = out_q.service;
	assign rsp.deselect_valid   = out_q.deselect_valid;
	assign rsp.deselect_service = out_q.deselect_service;
endmodule

// ===== hw/rtl/aidsr_ram.sv =====
module aidsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/aidsr_cmp.sv =====
module aidsr_cmp import aidsr_pkg::*; #(
	parameter int KEY_W = 128
) (
	input  logic [SVC_W+LEN_W+KEY_W-1:0] entry,
	input  logic [KEY_W-1:0]             key,
	input  logic [LEN_W-1:0]             key_len,
	output logic                         hit,
	output logic [SVC_W-1:0]             svc
);
	logic [LEN_W-1:0] ent_len;
	logic [KEY_W-1:0] ent_bytes;

	assign svc       = entry[SVC_W+LEN_W+KEY_W-1 -: SVC_W];
	assign ent_len   = entry[LEN_W+KEY_W-1 -: LEN_W];
	assign ent_bytes = entry[KEY_W-1:0];
	assign hit       = (ent_len == key_len) && (ent_bytes == key);
endmodule
